@@ design/fmf_pkg.sv @@
package fmf_pkg;

  // field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 14;
  localparam int unsigned MUL_W  = LEN_W + 4;
  localparam int unsigned TOT_W  = LEN_W + 2;

  // framing constants
  localparam logic [LEN_W-1:0] BUF_BYTES   = LEN_W'(8192);
  localparam logic [LEN_W-1:0] TRAILER_LEN = LEN_W'(7);
  localparam logic [LEN_W-1:0] LIMIT_MIN   = LEN_W'(16);
  localparam logic [LEN_W-1:0] ACC_MAX     = {LEN_W{1'b1}};

  // characters of interest
  localparam logic [BYTE_W-1:0] CHR_SOH   = 8'h01;
  localparam logic [BYTE_W-1:0] CHR_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CHR_NINE  = 8'h39;
  localparam logic [BYTE_W-1:0] CHR_EQUAL = 8'h3D;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_DIGITS = 2'd1,
    PH_COUNT  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              stream_start;
  } in_item_t;

  typedef struct packed {
    logic             frame_end;
    logic [LEN_W-1:0] frame_len;
    logic             length_overflow;
  } res_item_t;

endpackage

@@ design/fmf_in_stage.sv @@
module fmf_in_stage
  import fmf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     adv,
  output logic     s1_valid,
  output in_item_t s1_item
);

  logic     vld_r, vld_nxt;
  in_item_t item_r;
  logic     in_fire;

  // stage takes a new item when empty or when its item moves on
  assign in_ready = !vld_r || adv;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (in_fire) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = vld_r;
  assign s1_item  = item_r;

endmodule

@@ design/fmf_frame_step.sv @@
module fmf_frame_step
  import fmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  input  logic             step_en,
  input  in_item_t         item,
  output res_item_t        res
);

  // framer state
  phase_t           phase_r, phase_nxt;
  logic             nine_r, nine_nxt;
  logic             stop_r, stop_nxt;
  logic [LEN_W-1:0] acc_r, acc_nxt;
  logic [LEN_W-1:0] seen_r, seen_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  logic [LEN_W-1:0] lim_r, lim_nxt;

  // state as seen by this item, after an optional stream restart
  phase_t           phase_e;
  logic             nine_e;
  logic             stop_e;
  logic [LEN_W-1:0] acc_e;
  logic [LEN_W-1:0] seen_e;
  logic [LEN_W-1:0] left_e;

  logic [LEN_W-1:0] bs;
  logic [LEN_W-1:0] left_dec;
  logic [TOT_W-1:0] total;
  logic [LEN_W:0]   remain_w;
  logic [MUL_W-1:0] acc_mul;
  logic             is_soh, is_digit, is_nine, is_equal;
  logic             at_limit;
  logic             end_c, ovf_c;

  // clamp the limit when it is written
  always_comb begin
    lim_nxt = cfg_wr_data;
    if (cfg_wr_data > BUF_BYTES) begin
      lim_nxt = BUF_BYTES;
    end else if (cfg_wr_data < LIMIT_MIN) begin
      lim_nxt = LIMIT_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r <= BUF_BYTES;
    end else if (cfg_wr_en) begin
      lim_r <= lim_nxt;
    end
  end

  // restart clears the state before this byte
  assign phase_e = item.stream_start ? PH_SEARCH : phase_r;
  assign nine_e  = item.stream_start ? 1'b0 : nine_r;
  assign stop_e  = item.stream_start ? 1'b0 : stop_r;
  assign acc_e   = item.stream_start ? '0 : acc_r;
  assign seen_e  = item.stream_start ? '0 : seen_r;
  assign left_e  = item.stream_start ? '0 : left_r;

  // byte classes
  assign is_soh   = (item.rx_byte == CHR_SOH);
  assign is_nine  = (item.rx_byte == CHR_NINE);
  assign is_equal = (item.rx_byte == CHR_EQUAL);
  assign is_digit = (item.rx_byte >= CHR_ZERO) && (item.rx_byte <= CHR_NINE);

  // counts and lengths
  assign bs       = seen_e + LEN_W'(1);
  assign left_dec = (left_e != '0) ? (left_e - LEN_W'(1)) : left_e;
  assign remain_w = {1'b0, acc_e} + {1'b0, TRAILER_LEN};
  assign total    = {2'b00, bs} + {2'b00, acc_e} + {2'b00, TRAILER_LEN};
  assign at_limit = (bs >= lim_r);

  // decimal accumulate: acc * 10 + digit
  assign acc_mul = ({4'b0000, acc_e} << 3) + ({4'b0000, acc_e} << 1)
                 + {{(MUL_W-4){1'b0}}, 4'(item.rx_byte - CHR_ZERO)};

  // result of this byte
  always_comb begin
    end_c = 1'b0;
    ovf_c = 1'b0;
    case (phase_e)
      PH_COUNT: begin
        end_c = (left_dec == '0);
      end
      PH_DIGITS: begin
        if (is_soh) begin
          if (total > {2'b00, lim_r}) begin
            ovf_c = 1'b1;
          end else if (remain_w == '0) begin
            end_c = 1'b1;
          end
        end else begin
          ovf_c = at_limit;
        end
      end
      default: begin
        // searching for the length tag
        ovf_c = at_limit;
      end
    endcase
  end

  assign res.frame_end       = end_c;
  assign res.frame_len       = end_c ? bs : '0;
  assign res.length_overflow = ovf_c;

  // next state
  always_comb begin
    phase_nxt = phase_e;
    nine_nxt  = nine_e;
    stop_nxt  = stop_e;
    acc_nxt   = acc_e;
    seen_nxt  = bs;
    left_nxt  = left_e;
    case (phase_e)
      PH_COUNT: begin
        left_nxt = left_dec;
      end
      PH_DIGITS: begin
        if (is_soh) begin
          if (!ovf_c && (remain_w != '0)) begin
            phase_nxt = PH_COUNT;
            left_nxt  = remain_w[LEN_W-1:0];
          end
        end else if (!stop_e && is_digit) begin
          acc_nxt = (acc_mul > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_mul[LEN_W-1:0];
        end else begin
          stop_nxt = 1'b1;
        end
      end
      default: begin
        if (nine_e && is_equal) begin
          phase_nxt = PH_DIGITS;
          nine_nxt  = 1'b0;
        end else begin
          nine_nxt  = is_nine;
        end
      end
    endcase
    // re-arm after a frame ends or overflows
    if (end_c || ovf_c) begin
      phase_nxt = PH_SEARCH;
      nine_nxt  = 1'b0;
      stop_nxt  = 1'b0;
      acc_nxt   = '0;
      seen_nxt  = '0;
      left_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      nine_r  <= 1'b0;
      stop_r  <= 1'b0;
      acc_r   <= '0;
      seen_r  <= '0;
      left_r  <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      nine_r  <= nine_nxt;
      stop_r  <= stop_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

@@ design/fmf_out_stage.sv @@
module fmf_out_stage
  import fmf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  res_item_t res_in,
  output logic      adv,
  output logic      out_valid,
  input  logic      out_ready,
  output res_item_t res_out
);

  logic      vld_r, vld_nxt;
  res_item_t res_r;

  // register frees up when empty or when the item is taken
  assign adv = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // result capture
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign out_valid = vld_r;
  assign res_out   = res_r;

endmodule

@@ design/fix_message_framer_core.sv @@
// path: input register, then framing step, then result register
// throughput: one byte per cycle unless the output stalls; a byte enters the
// input register each cycle, and its framing step reads the state registers
// reset: synchronous, active low; clears the framer state and both stages,
// and returns the frame limit to 8192 bytes
module fix_message_framer_core
  import fmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration: max_frame_len
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  // input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] rx_byte
  input  logic             in_tuser,   // [0] stream_start
  // result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [15:0]      out_tdata,  // [13:0] frame_len, [15:14] zero
  output logic             out_tlast,  // frame_end
  output logic             out_tuser   // [0] length_overflow
);

  in_item_t  in_item;
  in_item_t  s1_item;
  logic      s1_valid;
  logic      adv;
  logic      step_fire;
  res_item_t step_res;
  res_item_t out_res;

  assign in_item.rx_byte      = in_tdata;
  assign in_item.stream_start = in_tuser;

  // input register
  fmf_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  assign step_fire = s1_valid && adv;

  // framing step and state
  fmf_frame_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_fire),
    .item        (s1_item),
    .res         (step_res)
  );

  // result register
  fmf_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step_fire),
    .res_in    (step_res),
    .adv       (adv),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res_out   (out_res)
  );

  assign out_tdata = {2'b00, out_res.frame_len};
  assign out_tlast = out_res.frame_end;
  assign out_tuser = out_res.length_overflow;

  // a frame cannot both end and overflow on the same byte
  a_end_ovf_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tlast && out_tuser))
    else $error("frame end and overflow on the same item");

  // length is zero unless the item ends a frame
  a_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tlast) |-> (out_tdata == 16'd0))
    else $error("nonzero length without frame end");

  // a reported frame is never empty and never beyond the buffer
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |->
      ((out_tdata[13:0] != 14'd0) && (out_tdata[13:0] <= BUF_BYTES)))
    else $error("frame length out of range");

  // a stalled input stage must keep the input channel closed
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !adv) |-> !in_tready)
    else $error("input accepted while stage is held");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import fmf_pkg::*;

  localparam int CYCLE_LIMIT      = 300000;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int DRAIN_CYCLES     = 8;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;
  logic             in_tvalid;
  logic             in_tready;
  logic [7:0]       in_tdata;   // [7:0] rx_byte
  logic             in_tuser;   // [0] stream_start
  logic             out_tvalid;
  logic             out_tready;
  logic [15:0]      out_tdata;  // [13:0] frame_len, [15:14] zero
  logic             out_tlast;  // frame_end
  logic             out_tuser;  // [0] length_overflow

  fix_message_framer_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // stimulus and expectation stores
  in_item_t  rx_byte_q[$];
  res_item_t framing_q[$];
  logic      start_next;
  int        n_bytes_queued;

  // framer mirror state
  phase_t           fr_phase;
  logic             fr_saw_nine;
  logic             fr_digits_stopped;
  int               fr_body_len;
  int               fr_seen;
  int               fr_left;
  logic [LEN_W-1:0] fr_limit_reg;

  // bookkeeping
  int   err_count;
  int   n_results;
  int   n_frames;
  int   n_overflows;
  int   n_limit_writes;
  int   cycle_count;
  logic in_taken;
  logic all_idle;

  // driver pacing
  int         burst_left;
  int         gap_left;
  logic [15:0] rdy_pat;
  logic [3:0]  rdy_pos;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void rearm_framer();
    fr_phase          = PH_SEARCH;
    fr_saw_nine       = 1'b0;
    fr_digits_stopped = 1'b0;
    fr_body_len       = 0;
    fr_seen           = 0;
    fr_left           = 0;
  endfunction

  // one framing step per received byte
  function automatic res_item_t frame_step(input logic [7:0] b, input logic start);
    res_item_t r;
    int        lim;
    int        total;
    int        v;
    r = '0;
    if (start) rearm_framer();
    lim = int'(fr_limit_reg);
    if (lim > int'(BUF_BYTES)) lim = int'(BUF_BYTES);
    if (lim < int'(LIMIT_MIN)) lim = int'(LIMIT_MIN);
    fr_seen++;
    case (fr_phase)
      PH_COUNT: begin
        if (fr_left > 0) fr_left--;
        if (fr_left == 0) begin
          r.frame_end = 1'b1;
          r.frame_len = LEN_W'(fr_seen);
        end
      end
      PH_DIGITS: begin
        if (b == CHR_SOH) begin
          total = fr_seen + fr_body_len + int'(TRAILER_LEN);
          if (total > lim) begin
            r.length_overflow = 1'b1;
          end else if (total == fr_seen) begin
            r.frame_end = 1'b1;
            r.frame_len = LEN_W'(fr_seen);
          end else begin
            fr_phase = PH_COUNT;
            fr_left  = total - fr_seen;
          end
        end else begin
          if (!fr_digits_stopped && b >= CHR_ZERO && b <= CHR_NINE) begin
            v = fr_body_len * 10 + int'(b - CHR_ZERO);
            fr_body_len = (v > int'(ACC_MAX)) ? int'(ACC_MAX) : v;
          end else begin
            fr_digits_stopped = 1'b1;
          end
          if (fr_seen >= lim) r.length_overflow = 1'b1;
        end
      end
      default: begin
        if (fr_saw_nine && b == CHR_EQUAL) begin
          fr_phase    = PH_DIGITS;
          fr_saw_nine = 1'b0;
        end else begin
          fr_saw_nine = (b == CHR_NINE);
        end
        if (fr_seen >= lim) r.length_overflow = 1'b1;
      end
    endcase
    if (r.frame_end || r.length_overflow) rearm_framer();
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    err_count++;
  endtask

  // byte queue builders
  task automatic add_byte(input logic [7:0] b);
    in_item_t it;
    it.rx_byte      = b;
    it.stream_start = start_next;
    rx_byte_q.push_back(it);
    start_next = 1'b0;
    n_bytes_queued++;
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  function automatic logic [7:0] non_digit();
    logic [7:0] v;
    do begin
      v = 8'($urandom_range(0, 255));
    end while (v == CHR_SOH || (v >= CHR_ZERO && v <= CHR_NINE));
    return v;
  endfunction

  // a complete message; a broken one carries junk after its length digits
  task automatic add_frame(input int blen, input bit with_prefix, input bit broken);
    if (with_prefix) begin
      add_text("8=FIX.4.4");
      add_byte(CHR_SOH);
    end
    add_text("9=");
    if (!(broken && blen == 0 && $urandom_range(0, 1) == 1)) begin
      if ($urandom_range(0, 4) == 0) add_text($sformatf("%04d", blen));
      else add_text($sformatf("%0d", blen));
    end
    if (broken) begin
      add_byte(non_digit());
      add_text($sformatf("%0d", $urandom_range(0, 99)));
    end
    add_byte(CHR_SOH);
    repeat (blen) add_byte(8'($urandom_range(0, 255)));
    add_text($sformatf("10=%03d", $urandom_range(0, 255)));
    add_byte(CHR_SOH);
  endtask

  // a length field far too long for any limit
  task automatic add_huge_length();
    add_text("9=9");
    repeat ($urandom_range(4, 19)) add_byte(CHR_ZERO + 8'($urandom_range(0, 9)));
    add_byte(CHR_SOH);
  endtask

  task automatic add_random(input int n);
    int stop_at;
    int kind;
    int blen;
    stop_at = n_bytes_queued + n;
    while (n_bytes_queued < stop_at) begin
      kind = $urandom_range(0, 15);
      blen = ($urandom_range(0, 3) == 0) ? $urandom_range(21, 60) : $urandom_range(0, 20);
      if (kind < 10) begin
        if ($urandom_range(0, 2) == 0) start_next = 1'b1;
        add_frame(blen, $urandom_range(0, 1), 1'b0);
      end else if (kind < 12) begin
        add_frame(blen, $urandom_range(0, 1), 1'b1);
      end else if (kind == 12) begin
        add_huge_length();
      end else if (kind == 13) begin
        repeat ($urandom_range(1, 30)) add_byte(8'($urandom_range(0, 255)));
      end else if (kind == 14) begin
        start_next = 1'b1;
      end else begin
        // a message cut short, then fresh traffic
        add_text("9=");
        add_text($sformatf("%0d", blen));
        add_byte(CHR_SOH);
        repeat ($urandom_range(0, blen)) add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic wait_idle();
    @(posedge clk);
    @(negedge clk);
    while (!all_idle) @(negedge clk);
  endtask

  task automatic write_limit(input int v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= LEN_W'(v);
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    n_limit_writes++;
  endtask

  // sender: bursts of items separated by random gaps
  always @(negedge clk) begin
    in_item_t cur;
    if (rst_n && (!in_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        in_tvalid <= 1'b0;
        gap_left--;
      end else if (rx_byte_q.size() > 0) begin
        cur = rx_byte_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= cur.rx_byte;
        in_tuser  <= cur.stream_start;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver: ready follows a 16-bit pattern, reloaded each time the position wraps
  always @(negedge clk) begin
    out_tready <= rdy_pat[rdy_pos];
    rdy_pos = rdy_pos + 4'd1;
    if (rdy_pos == 4'd0) begin
      case ($urandom_range(0, 3))
        0: rdy_pat = 16'hFFFF;
        1: rdy_pat = 16'h8000;
        default: rdy_pat = 16'($urandom) | 16'h0001;
      endcase
    end
  end

  // mirror the framer on accepted items and check each result item
  always @(posedge clk) begin
    res_item_t want;
    if (!rst_n) begin
      rearm_framer();
      fr_limit_reg = BUF_BYTES;
      in_taken <= 1'b0;
      all_idle <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (cfg_wr_en) fr_limit_reg = cfg_wr_data;
      if (in_tvalid && in_tready) framing_q.push_back(frame_step(in_tdata, in_tuser));
      if (out_tvalid && out_tready) begin
        n_results++;
        if (framing_q.size() == 0) begin
          report_mismatch("unexpected item", 1, 0);
        end else begin
          want = framing_q.pop_front();
          if (want.frame_end) n_frames++;
          if (want.length_overflow) n_overflows++;
          if (out_tlast !== want.frame_end)
            report_mismatch("frame_end", out_tlast, want.frame_end);
          if (out_tdata !== {2'b00, want.frame_len})
            report_mismatch("frame_len", out_tdata, want.frame_len);
          if (out_tuser !== want.length_overflow)
            report_mismatch("length_overflow", out_tuser, want.length_overflow);
        end
      end
      all_idle <= (rx_byte_q.size() == 0) && !in_tvalid && (framing_q.size() == 0);
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    int limit_plan[7];
    int i;
    limit_plan = '{16, 8192, 0, 16383, 40, 13, 8191};
    limit_plan[4] = $urandom_range(17, 300);
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = '0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    start_next     = 1'b0;
    n_bytes_queued = 0;
    err_count      = 0;
    n_results      = 0;
    n_frames       = 0;
    n_overflows    = 0;
    n_limit_writes = 0;
    cycle_count    = 0;
    burst_left     = 1;
    gap_left       = 0;
    rdy_pat        = 16'hFFFF;
    rdy_pos        = 4'd0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // empty length field, all-ones and all-zero bytes in the trailer
    start_next = 1'b1;
    add_text("9=");
    add_byte(CHR_SOH);
    add_text("10=");
    add_byte(8'hFF);
    add_byte(8'h00);
    add_text("7");
    add_byte(CHR_SOH);
    // leading non-digit gives a zero body length
    add_text("9=x");
    add_byte(CHR_SOH);
    add_text("10=123");
    add_byte(CHR_SOH);
    // saturating length overflows on its terminating byte
    add_text("9=99999");
    add_byte(CHR_SOH);

    add_random(RANDOM_PER_PHASE);
    wait_idle();

    // sweep the frame limit, including values that get clamped
    for (i = 0; i < 7; i++) begin
      write_limit(limit_plan[i]);
      add_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d bytes under %0d frame limit settings", n_bytes_queued,
             n_limit_writes + 1);
    $display("%0d results checked: %0d frames ended, %0d overflows", n_results, n_frames,
             n_overflows);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
